// ===== rtl/core/htsd_pkg.sv =====
// htsd_pkg: shared types and constants of the huffman tree stream decoder
// no dependencies; used by every module under rtl/core except htsd_checker
package htsd_pkg;

  // default sizes of node table and open-node stack
  localparam int unsigned MaxNodesDef   = 512;
  localparam int unsigned StackDepthDef = 256;

  // fixed field widths
  localparam int unsigned SymW      = 8;
  localparam int unsigned SymCountW = 9;
  localparam int unsigned CharW     = 32;
  localparam int unsigned CfgW      = 32;

  localparam logic [SymCountW-1:0] SymbolCountRst = 9'd2;
  localparam logic [CharW-1:0]     CharCountRst   = 32'd0;

  // configuration register indexes
  localparam logic CfgSymbolCount = 1'b0;
  localparam logic CfgCharCount   = 1'b1;

  // decoder phase
  typedef enum logic [1:0] {
    PH_TREE,
    PH_WALK,
    PH_DONE,
    PH_ERR
  } phase_e;

  // bit sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BIT,
    ST_LINK_L,
    ST_LEAF_PARENT,
    ST_LINK_R,
    ST_WALK_RD,
    ST_WALK_NEXT,
    ST_FLUSH
  } state_e;

  // node table write command
  typedef struct packed {
    logic init;   // fresh internal node, no children
    logic leaf;   // mark leaf and store symbol
    logic left;   // set left child
    logic right;  // set right child
  } node_we_t;

endpackage

// ===== rtl/core/huffman_tree_stream_decoder_unit.sv =====
// huffman_tree_stream_decoder_unit: top level, bit sequencer and result buffering
// depends on htsd_pkg, htsd_node_table, htsd_stack
//
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------------
//  input    | in_valid_i / in_stall_o | data_byte_i
//  output   | out_valid_o/ out_stall_i| symbol_o last_of_byte_o stream_done_o error_flag_o
//  config   | cfg_we_i                | cfg_idx_i cfg_data_i
//
// a transaction steps from its accept in ST_IDLE through ST_BIT once per bit: an opened left
// child adds ST_LINK_L, a completed leaf with a parent adds ST_LEAF_PARENT and ST_LINK_R,
// a tree walk bit adds ST_WALK_RD and ST_WALK_NEXT for the registered single read port of the
// node table, and ST_FLUSH ends each byte; once the stream is done or in error the rest of the byte is skipped.
// reset or any config write restarts tree loading; no clearing pass is needed.
// a stalled output holds the sequencer while a buffered result of the byte cannot move on.
module huffman_tree_stream_decoder_unit #(
  parameter int unsigned MAX_NODES   = htsd_pkg::MaxNodesDef,
  parameter int unsigned STACK_DEPTH = htsd_pkg::StackDepthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [htsd_pkg::CfgW-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                data_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [7:0]                symbol_o,
  output logic                      last_of_byte_o,
  output logic                      stream_done_o,
  output logic                      error_flag_o
);
  localparam int unsigned NW  = $clog2(MAX_NODES);
  localparam int unsigned NUW = $clog2(MAX_NODES + 1);
  localparam int unsigned SAW = $clog2(STACK_DEPTH);
  localparam int unsigned SDW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SCW = htsd_pkg::SymCountW;
  localparam int unsigned CW  = htsd_pkg::CharW;

  htsd_pkg::state_e state_q, state_d;
  htsd_pkg::phase_e phase_q, phase_d;

  logic [SCW-1:0] sym_count_q, sym_count_d;
  logic [CW-1:0]  char_count_q, char_count_d;
  logic [SCW-1:0] syms_left_q, syms_left_d;
  logic [CW-1:0]  chars_left_q, chars_left_d;
  logic [3:0]     lbits_q, lbits_d;
  logic [7:0]     lshift_q, lshift_d;
  logic [NW-1:0]  walk_q, walk_d;
  logic [NW-1:0]  tos_q, tos_d;
  logic [SDW-1:0] st_top_q, st_top_d;
  logic [NUW-1:0] used_q, used_d;
  logic [7:0]     byte_q, byte_d;
  logic [2:0]     bidx_q, bidx_d;

  logic           pend_valid_q, pend_valid_d;
  logic [7:0]     pend_sym_q, pend_sym_d;
  logic           pend_done_q, pend_done_d;
  logic           pend_err_q, pend_err_d;
  logic           out_valid_q, out_valid_d;
  logic [7:0]     out_sym_q, out_sym_d;
  logic           out_last_q, out_last_d;
  logic           out_done_q, out_done_d;
  logic           out_err_q, out_err_d;

  htsd_pkg::node_we_t node_we;
  logic [NW-1:0]  node_waddr, node_wchild, node_raddr;
  logic [7:0]     node_wsym;
  logic           rd_leaf, root_leaf;
  logic [7:0]     rd_sym;
  logic [NW-1:0]  rd_left, rd_right;

  logic           stk_we;
  logic [NW-1:0]  stk_rdata;
  logic [SDW-1:0] st_top_m1, st_top_m2;

  logic           cur_bit, out_free, adv, emit, emit_done, emit_err, restart;
  logic [7:0]     emit_sym, new_shift;
  logic [NW-1:0]  walk_next;

  assign st_top_m1 = st_top_q - SDW'(1);
  assign st_top_m2 = st_top_q - SDW'(2);
  assign cur_bit   = byte_q[bidx_q];
  assign out_free  = !out_valid_q || !out_stall_i;
  assign new_shift = {cur_bit, lshift_q[7:1]};
  assign walk_next = cur_bit ? rd_right : rd_left;
  assign restart   = cfg_we_i;

  assign in_stall_o     = (state_q != htsd_pkg::ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign symbol_o       = out_sym_q;
  assign last_of_byte_o = out_last_q;
  assign stream_done_o  = out_done_q;
  assign error_flag_o   = out_err_q;

  htsd_node_table #(.MAX_NODES(MAX_NODES)) u_nodes (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .restart_i  (restart),
    .we_i       (node_we),
    .waddr_i    (node_waddr),
    .wsym_i     (node_wsym),
    .wchild_i   (node_wchild),
    .raddr_i    (node_raddr),
    .rd_leaf_o  (rd_leaf),
    .rd_sym_o   (rd_sym),
    .rd_left_o  (rd_left),
    .rd_right_o (rd_right),
    .root_leaf_o(root_leaf)
  );

  htsd_stack #(.MAX_NODES(MAX_NODES), .STACK_DEPTH(STACK_DEPTH)) u_stack (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(st_top_m1[SAW-1:0]),
    .wdata_i(tos_q),
    .raddr_i(st_top_m2[SAW-1:0]),
    .rdata_o(stk_rdata)
  );

  // sequencer next state
  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    sym_count_d  = sym_count_q;
    char_count_d = char_count_q;
    syms_left_d  = syms_left_q;
    chars_left_d = chars_left_q;
    lbits_d      = lbits_q;
    lshift_d     = lshift_q;
    walk_d       = walk_q;
    tos_d        = tos_q;
    st_top_d     = st_top_q;
    used_d       = used_q;
    byte_d       = byte_q;
    bidx_d       = bidx_q;
    pend_valid_d = pend_valid_q;
    pend_sym_d   = pend_sym_q;
    pend_done_d  = pend_done_q;
    pend_err_d   = pend_err_q;
    out_valid_d  = out_valid_q;
    out_sym_d    = out_sym_q;
    out_last_d   = out_last_q;
    out_done_d   = out_done_q;
    out_err_d    = out_err_q;
    node_we      = '0;
    node_waddr   = tos_q;
    node_wchild  = used_q[NW-1:0];
    node_wsym    = new_shift;
    node_raddr   = walk_q;
    stk_we       = 1'b0;
    adv          = 1'b0;
    emit         = 1'b0;
    emit_sym     = '0;
    emit_done    = 1'b0;
    emit_err     = 1'b0;

    // output register drains on a completed transaction
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      htsd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          byte_d  = data_byte_i;
          bidx_d  = '0;
          state_d = htsd_pkg::ST_BIT;
        end
      end
      htsd_pkg::ST_BIT: begin
        if (phase_q == htsd_pkg::PH_DONE || phase_q == htsd_pkg::PH_ERR) begin
          state_d = htsd_pkg::ST_FLUSH;
        end else if (!pend_valid_q || out_free) begin
          if (phase_q == htsd_pkg::PH_WALK) begin
            state_d = htsd_pkg::ST_WALK_RD;
          end else if (lbits_q != 4'd0) begin
            // symbol bit of a leaf
            lshift_d = new_shift;
            lbits_d  = lbits_q - 4'd1;
            if (lbits_q != 4'd1) begin
              adv = 1'b1;
            end else if (st_top_q == '0) begin
              emit = 1'b1; emit_err = 1'b1;
            end else begin
              node_we.leaf = 1'b1;
              st_top_d     = st_top_m1;
              syms_left_d  = syms_left_q - SCW'(1);
              if (syms_left_q == SCW'(1)) begin
                if (root_leaf || tos_q == '0) begin
                  emit = 1'b1; emit_err = 1'b1;
                end else begin
                  walk_d  = '0;
                  phase_d = (chars_left_q == '0) ? htsd_pkg::PH_DONE : htsd_pkg::PH_WALK;
                  adv     = 1'b1;
                end
              end else if (st_top_m1 == '0) begin
                emit = 1'b1; emit_err = 1'b1;
              end else begin
                state_d = htsd_pkg::ST_LEAF_PARENT;
              end
            end
          end else if (syms_left_q == '0 || st_top_q == '0) begin
            emit = 1'b1; emit_err = 1'b1;
          end else if (cur_bit) begin
            lbits_d  = 4'd8;
            lshift_d = '0;
            adv      = 1'b1;
          end else if (st_top_q >= SDW'(STACK_DEPTH) || used_q >= NUW'(MAX_NODES)) begin
            emit = 1'b1; emit_err = 1'b1;
          end else begin
            node_we.init = 1'b1;
            node_waddr   = used_q[NW-1:0];
            state_d      = htsd_pkg::ST_LINK_L;
          end
        end
      end
      htsd_pkg::ST_LINK_L: begin
        // link left child, push old top
        node_we.left = 1'b1;
        stk_we       = 1'b1;
        tos_d        = used_q[NW-1:0];
        st_top_d     = st_top_q + SDW'(1);
        used_d       = used_q + NUW'(1);
        adv          = 1'b1;
      end
      htsd_pkg::ST_LEAF_PARENT: begin
        // parent popped from stack memory
        if (used_q >= NUW'(MAX_NODES)) begin
          emit = 1'b1; emit_err = 1'b1;
        end else begin
          node_we.init = 1'b1;
          node_waddr   = used_q[NW-1:0];
          tos_d        = stk_rdata;
          state_d      = htsd_pkg::ST_LINK_R;
        end
      end
      htsd_pkg::ST_LINK_R: begin
        node_we.right = 1'b1;
        tos_d         = used_q[NW-1:0];
        used_d        = used_q + NUW'(1);
        adv           = 1'b1;
      end
      htsd_pkg::ST_WALK_RD: begin
        if (walk_next == '0) begin
          emit = 1'b1; emit_err = 1'b1;
        end else begin
          node_raddr = walk_next;
          walk_d     = walk_next;
          state_d    = htsd_pkg::ST_WALK_NEXT;
        end
      end
      htsd_pkg::ST_WALK_NEXT: begin
        if (rd_leaf) begin
          chars_left_d = chars_left_q - CW'(1);
          emit         = 1'b1;
          emit_sym     = rd_sym;
          emit_done    = (chars_left_q == CW'(1));
          walk_d       = '0;
          if (chars_left_q == CW'(1)) begin
            phase_d = htsd_pkg::PH_DONE;
          end
        end
        adv = 1'b1;
      end
      htsd_pkg::ST_FLUSH: begin
        // last result of the byte leaves the buffer
        if (!pend_valid_q) begin
          state_d = htsd_pkg::ST_IDLE;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_sym_d    = pend_sym_q;
          out_last_d   = 1'b1;
          out_done_d   = pend_done_q;
          out_err_d    = pend_err_q;
          pend_valid_d = 1'b0;
          state_d      = htsd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = htsd_pkg::ST_IDLE;
      end
    endcase

    // errors end the phase
    if (emit_err) begin
      phase_d = htsd_pkg::PH_ERR;
      adv     = 1'b1;
    end

    // new result pushes the older one out as not last
    if (emit) begin
      if (pend_valid_q) begin
        out_valid_d = 1'b1;
        out_sym_d   = pend_sym_q;
        out_last_d  = 1'b0;
        out_done_d  = pend_done_q;
        out_err_d   = pend_err_q;
      end
      pend_valid_d = 1'b1;
      pend_sym_d   = emit_sym;
      pend_done_d  = emit_done;
      pend_err_d   = emit_err;
    end

    // step to the next bit
    if (adv) begin
      if (bidx_q == 3'd7) begin
        state_d = htsd_pkg::ST_FLUSH;
      end else begin
        bidx_d  = bidx_q + 3'd1;
        state_d = htsd_pkg::ST_BIT;
      end
    end

    // config write restarts the decoder
    if (restart) begin
      if (cfg_idx_i == htsd_pkg::CfgSymbolCount) begin
        sym_count_d = cfg_data_i[SCW-1:0];
      end else begin
        char_count_d = cfg_data_i[CW-1:0];
      end
      syms_left_d  = (cfg_idx_i == htsd_pkg::CfgSymbolCount) ? cfg_data_i[SCW-1:0]
                                                            : sym_count_q;
      chars_left_d = (cfg_idx_i == htsd_pkg::CfgCharCount) ? cfg_data_i[CW-1:0]
                                                          : char_count_q;
      phase_d  = htsd_pkg::PH_TREE;
      lbits_d  = '0;
      lshift_d = '0;
      walk_d   = '0;
      tos_d    = '0;
      st_top_d = SDW'(1);
      used_d   = NUW'(1);
      node_we  = '0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= htsd_pkg::ST_IDLE;
      phase_q      <= htsd_pkg::PH_TREE;
      sym_count_q  <= htsd_pkg::SymbolCountRst;
      char_count_q <= htsd_pkg::CharCountRst;
      syms_left_q  <= htsd_pkg::SymbolCountRst;
      chars_left_q <= htsd_pkg::CharCountRst;
      lbits_q      <= '0;
      lshift_q     <= '0;
      walk_q       <= '0;
      tos_q        <= '0;
      st_top_q     <= SDW'(1);
      used_q       <= NUW'(1);
      bidx_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      sym_count_q  <= sym_count_d;
      char_count_q <= char_count_d;
      syms_left_q  <= syms_left_d;
      chars_left_q <= chars_left_d;
      lbits_q      <= lbits_d;
      lshift_q     <= lshift_d;
      walk_q       <= walk_d;
      tos_q        <= tos_d;
      st_top_q     <= st_top_d;
      used_q       <= used_d;
      bidx_q       <= bidx_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    byte_q      <= byte_d;
    pend_sym_q  <= pend_sym_d;
    pend_done_q <= pend_done_d;
    pend_err_q  <= pend_err_d;
    out_sym_q   <= out_sym_d;
    out_last_q  <= out_last_d;
    out_done_q  <= out_done_d;
    out_err_q   <= out_err_d;
  end

endmodule

// ===== rtl/core/htsd_node_table.sv =====
// htsd_node_table: node table memories with root entry held in registers
// depends on htsd_pkg
module htsd_node_table #(
  parameter int unsigned MAX_NODES = htsd_pkg::MaxNodesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         restart_i,
  input  htsd_pkg::node_we_t           we_i,
  input  logic [$clog2(MAX_NODES)-1:0] waddr_i,
  input  logic [htsd_pkg::SymW-1:0]    wsym_i,
  input  logic [$clog2(MAX_NODES)-1:0] wchild_i,
  input  logic [$clog2(MAX_NODES)-1:0] raddr_i,
  output logic                         rd_leaf_o,
  output logic [htsd_pkg::SymW-1:0]    rd_sym_o,
  output logic [$clog2(MAX_NODES)-1:0] rd_left_o,
  output logic [$clog2(MAX_NODES)-1:0] rd_right_o,
  output logic                         root_leaf_o
);
  localparam int unsigned NW = $clog2(MAX_NODES);

  logic                    leaf_mem  [MAX_NODES];
  logic [htsd_pkg::SymW-1:0] sym_mem [MAX_NODES];
  logic [NW-1:0]           left_mem  [MAX_NODES];
  logic [NW-1:0]           right_mem [MAX_NODES];

  logic          root_leaf_q;
  logic [NW-1:0] root_left_q;
  logic [NW-1:0] root_right_q;
  logic          waddr_root;
  logic          raddr_root;

  assign waddr_root  = (waddr_i == '0);
  assign raddr_root  = (raddr_i == '0);
  assign root_leaf_o = root_leaf_q;

  // root entry, cleared on restart
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_leaf_q  <= 1'b0;
      root_left_q  <= '0;
      root_right_q <= '0;
    end else if (restart_i) begin
      root_leaf_q  <= 1'b0;
      root_left_q  <= '0;
      root_right_q <= '0;
    end else if (waddr_root) begin
      if (we_i.leaf)  root_leaf_q  <= 1'b1;
      if (we_i.left)  root_left_q  <= wchild_i;
      if (we_i.right) root_right_q <= wchild_i;
    end
  end

  // memory writes for all other nodes
  always_ff @(posedge clk_i) begin
    if (!waddr_root) begin
      if (we_i.init || we_i.leaf) begin
        leaf_mem[waddr_i] <= we_i.leaf;
        sym_mem[waddr_i]  <= we_i.leaf ? wsym_i : '0;
      end
      if (we_i.init || we_i.left) begin
        left_mem[waddr_i] <= we_i.left ? wchild_i : '0;
      end
      if (we_i.init || we_i.right) begin
        right_mem[waddr_i] <= we_i.right ? wchild_i : '0;
      end
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    if (raddr_root) begin
      rd_leaf_o  <= root_leaf_q;
      rd_sym_o   <= '0;
      rd_left_o  <= root_left_q;
      rd_right_o <= root_right_q;
    end else begin
      rd_leaf_o  <= leaf_mem[raddr_i];
      rd_sym_o   <= sym_mem[raddr_i];
      rd_left_o  <= left_mem[raddr_i];
      rd_right_o <= right_mem[raddr_i];
    end
  end

endmodule

// ===== rtl/core/htsd_stack.sv =====
// htsd_stack: memory for open-node stack entries below the top of stack
// depends on htsd_pkg for parameter defaults
module htsd_stack #(
  parameter int unsigned MAX_NODES   = htsd_pkg::MaxNodesDef,
  parameter int unsigned STACK_DEPTH = htsd_pkg::StackDepthDef
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [$clog2(STACK_DEPTH)-1:0] waddr_i,
  input  logic [$clog2(MAX_NODES)-1:0]   wdata_i,
  input  logic [$clog2(STACK_DEPTH)-1:0] raddr_i,
  output logic [$clog2(MAX_NODES)-1:0]   rdata_o
);
  logic [$clog2(MAX_NODES)-1:0] mem [STACK_DEPTH];

  // single write, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/core/htsd_checker.sv =====
// htsd_checker: port-level assertions for the decoder top level
// depends on huffman_tree_stream_decoder_unit; bound below
module htsd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] symbol_o,
  input logic       last_of_byte_o,
  input logic       stream_done_o,
  input logic       error_flag_o
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(symbol_o)
      && $stable(last_of_byte_o) && $stable(error_flag_o))
    else $error("stalled result changed");

  // error results carry no symbol and never finish the stream
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_flag_o |-> symbol_o == 8'd0 && !stream_done_o)
    else $error("malformed error result");

  // an accepted byte keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted on back-to-back cycles");

endmodule

bind huffman_tree_stream_decoder_unit htsd_checker u_htsd_checker (.*);

// ===== tb/tb_top.sv =====
// tb_top: self-checking testbench of huffman_tree_stream_decoder_unit
// depends on htsd_pkg and the decoder rtl; builds random serialized trees,
// encodes symbols with them and checks every decoded result against a local predictor
`timescale 1ns / 100ps

module tb_top;

  localparam int NODES = 512;
  localparam int DEPTH = 256;
  localparam int LATENCY_WAIT = 60;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
    logic       done;
    logic       err;
  } dec_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = htsd_pkg::CfgSymbolCount;
  logic [htsd_pkg::CfgW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [7:0] data_byte_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [7:0] symbol_o;
  logic last_of_byte_o, stream_done_o, error_flag_o;

  huffman_tree_stream_decoder_unit uut (.*);

  always #10 clk_i = ~clk_i;

  // decoder model state
  logic       nd_leaf [NODES];
  logic [7:0] nd_sym [NODES];
  logic [9:0] nd_left [NODES];
  logic [9:0] nd_right [NODES];
  logic [9:0] open_nodes [DEPTH];
  int unsigned sp, used, syms_left, leaf_bits;
  logic [8:0]  sym_count_reg;
  logic [31:0] char_count_reg, chars_left;
  logic [7:0]  leaf_shift;
  logic [9:0]  walk_at;
  htsd_pkg::phase_e dec_phase;

  dec_result_t pending_results[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int error_results = 0;
  bit tx_busy_mode = 1'b1;
  bit rx_busy_mode = 1'b1;
  int rx_long_hold = 0;
  int rx_wait = 0;
  int rx_seen_mark = 0;

  // stream under construction
  logic         stream_bits[$];
  logic [255:0] code_v[256];
  int           code_n[256];
  int           leaf_cnt;

  function automatic void model_restart();
    for (int i = 0; i < NODES; i++) begin
      nd_leaf[i] = 0; nd_sym[i] = 0; nd_left[i] = 0; nd_right[i] = 0;
    end
    sp = 1; open_nodes[0] = 0; used = 1;
    dec_phase = htsd_pkg::PH_TREE;
    syms_left = 32'(sym_count_reg);
    chars_left = char_count_reg;
    leaf_bits = 0; leaf_shift = 0; walk_at = 0;
  endfunction

  // allocate a fresh internal node, zero when the table is full
  function automatic int alloc_node();
    int idx;
    if (used >= NODES) return 0;
    idx = used++;
    nd_leaf[idx] = 0; nd_sym[idx] = 0; nd_left[idx] = 0; nd_right[idx] = 0;
    return idx;
  endfunction

  // one tree loading bit, returns 1 on error
  function automatic bit tree_bit(logic b);
    int top, child;
    if (leaf_bits > 0) begin
      leaf_shift = {b, leaf_shift[7:1]};
      leaf_bits--;
      if (leaf_bits > 0) return 0;
      if (sp == 0) return 1;
      top = int'(open_nodes[sp-1]);
      nd_leaf[top] = 1; nd_sym[top] = leaf_shift;
      sp--; syms_left--;
      if (syms_left == 0) begin
        if (nd_leaf[0]) return 1;
        walk_at = 0;
        dec_phase = (chars_left == 0) ? htsd_pkg::PH_DONE : htsd_pkg::PH_WALK;
        return 0;
      end
      if (sp == 0) return 1;
      top = int'(open_nodes[sp-1]);
      sp--;
      child = alloc_node();
      if (child == 0) return 1;
      nd_right[top] = 10'(child);
      open_nodes[sp++] = 10'(child);
      return 0;
    end
    if (syms_left == 0 || sp == 0) return 1;
    if (b) begin
      leaf_bits = 8; leaf_shift = 0;
      return 0;
    end
    if (sp >= DEPTH) return 1;
    top = int'(open_nodes[sp-1]);
    child = alloc_node();
    if (child == 0) return 1;
    nd_left[top] = 10'(child);
    open_nodes[sp++] = 10'(child);
    return 0;
  endfunction

  // expected results of one accepted byte
  function automatic void decode_byte(logic [7:0] d);
    dec_result_t r;
    dec_result_t res[$];
    logic [9:0] nxt;
    for (int i = 0; i < 8; i++) begin
      if (dec_phase == htsd_pkg::PH_TREE) begin
        if (tree_bit(d[i])) begin
          r = '{symbol: 8'd0, last: 1'b0, done: 1'b0, err: 1'b1};
          res.insert(res.size(), r);
          dec_phase = htsd_pkg::PH_ERR;
        end
      end else if (dec_phase == htsd_pkg::PH_WALK) begin
        nxt = d[i] ? nd_right[walk_at[8:0]] : nd_left[walk_at[8:0]];
        if (nxt == 0 || nxt >= NODES) begin
          r = '{symbol: 8'd0, last: 1'b0, done: 1'b0, err: 1'b1};
          res.insert(res.size(), r);
          dec_phase = htsd_pkg::PH_ERR;
        end else if (nd_leaf[nxt[8:0]]) begin
          chars_left--;
          r = '{symbol: nd_sym[nxt[8:0]], last: 1'b0, done: (chars_left == 0), err: 1'b0};
          res.insert(res.size(), r);
          walk_at = 0;
          if (chars_left == 0) dec_phase = htsd_pkg::PH_DONE;
        end else begin
          walk_at = nxt;
        end
      end
    end
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
    foreach (res[k]) pending_results.insert(pending_results.size(), res[k]);
  endfunction

  // result checker
  always @(posedge clk_i) begin
    dec_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (error_flag_o) error_results++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result sym=%h last=%b done=%b err=%b", $time,
                 symbol_o, last_of_byte_o, stream_done_o, error_flag_o);
      end else begin
        e = pending_results.pop_front();
        if (symbol_o !== e.symbol) begin
          errors++;
          $display("%0t: symbol expected %h actual %h", $time, e.symbol, symbol_o);
        end
        if (last_of_byte_o !== e.last) begin
          errors++;
          $display("%0t: last_of_byte expected %b actual %b", $time, e.last, last_of_byte_o);
        end
        if (stream_done_o !== e.done) begin
          errors++;
          $display("%0t: stream_done expected %b actual %b", $time, e.done, stream_done_o);
        end
        if (error_flag_o !== e.err) begin
          errors++;
          $display("%0t: error_flag expected %b actual %b", $time, e.err, error_flag_o);
        end
      end
    end
  end

  // receiver idling: a fresh wait per result, with an optional long hold-off
  always @(negedge clk_i) begin
    if (results_seen != rx_seen_mark) begin
      rx_seen_mark = results_seen;
      rx_wait = rx_busy_mode ? $urandom_range(0, 7) : 0;
    end
    if (rx_long_hold > 0) begin
      out_stall_i <= 1'b1;
      rx_long_hold = rx_long_hold - 1;
    end else if (rx_wait > 0) begin
      out_stall_i <= 1'b1;
      rx_wait = rx_wait - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_byte(logic [7:0] d);
    int gap;
    gap = tx_busy_mode ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    data_byte_i = d;
    do @(posedge clk_i); while (in_stall_o);
    decode_byte(d);
    items_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // pause until every expected result is out and the block has settled
  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (pending_results.size() > 0) @(negedge clk_i);
    repeat (LATENCY_WAIT) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [31:0] val);
    wait_drained();
    cfg_we_i = 1'b1; cfg_idx_i = idx; cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == htsd_pkg::CfgSymbolCount) sym_count_reg = val[8:0];
    else char_count_reg = val;
    model_restart();
  endtask

  task automatic put_bit(logic b);
    stream_bits.insert(stream_bits.size(), b);
  endtask

  task automatic push_leaf(logic [7:0] s);
    put_bit(1'b1);
    for (int i = 0; i < 8; i++) put_bit(s[i]);
  endtask

  // pre-order serialization of a random full tree with n leaves
  task automatic build_tree(int n, logic [255:0] path, int lvl);
    logic [255:0] rp;
    int k;
    if (n == 1) begin
      push_leaf(8'($urandom));
      code_v[leaf_cnt] = path;
      code_n[leaf_cnt] = lvl;
      leaf_cnt++;
    end else begin
      put_bit(1'b0);
      k = $urandom_range(1, n - 1);
      build_tree(k, path, lvl + 1);
      rp = path;
      rp[lvl] = 1'b1;
      build_tree(n - k, rp, lvl + 1);
    end
  endtask

  // pack pending bits least significant first, pad with random bits
  task automatic flush_bits();
    logic [7:0] d;
    while (stream_bits.size() > 0) begin
      d = 8'($urandom);
      for (int i = 0; i < 8 && stream_bits.size() > 0; i++) d[i] = stream_bits.pop_front();
      send_byte(d);
    end
  endtask

  // configure, serialize a tree, encode symbols, optionally corrupt, then extra noise
  task automatic run_stream(int n, logic [31:0] chars, int coded, int extra, bit corrupt);
    int pick;
    write_cfg(htsd_pkg::CfgSymbolCount, n);
    write_cfg(htsd_pkg::CfgCharCount, chars);
    stream_bits.delete();
    leaf_cnt = 0;
    build_tree(n, '0, 0);
    for (int c = 0; c < coded; c++) begin
      pick = $urandom_range(0, leaf_cnt - 1);
      for (int i = 0; i < code_n[pick]; i++) put_bit(code_v[pick][i]);
    end
    if (corrupt) begin
      pick = $urandom_range(0, stream_bits.size() - 1);
      stream_bits[pick] = ~stream_bits[pick];
    end
    flush_bits();
    repeat (extra) send_byte(8'($urandom));
  endtask

  // ---- tests ----

  task automatic test_reset_defaults();
    // two leaves, zero characters: tree loads, later bytes produce nothing
    stream_bits.delete();
    put_bit(1'b0);
    push_leaf(8'h00);
    push_leaf(8'hff);
    flush_bits();
    send_byte(8'h00);
    send_byte(8'hff);
  endtask

  task automatic test_empty_tree();
    write_cfg(htsd_pkg::CfgSymbolCount, 0);
    send_byte(8'h00);
    send_byte(8'hff);
  endtask

  task automatic test_single_symbol();
    run_stream(1, 3, 0, 2, 0);
  endtask

  task automatic test_missing_child();
    // only the root's left leaf exists, a right step finds no child
    write_cfg(htsd_pkg::CfgSymbolCount, 1);
    write_cfg(htsd_pkg::CfgCharCount, 5);
    stream_bits.delete();
    put_bit(1'b0);
    push_leaf(8'h5a);
    put_bit(1'b0);
    put_bit(1'b1);
    flush_bits();
    send_byte(8'h00);
  endtask

  task automatic test_stack_full();
    write_cfg(htsd_pkg::CfgSymbolCount, 256);
    write_cfg(htsd_pkg::CfgCharCount, 1);
    repeat (33) send_byte(8'h00);
  endtask

  task automatic test_node_table_full();
    // fill the stack with left children, then alternate leaf and left child
    // until the table runs out
    write_cfg(htsd_pkg::CfgSymbolCount, 256);
    write_cfg(htsd_pkg::CfgCharCount, 1);
    stream_bits.delete();
    for (int i = 0; i < 255; i++) put_bit(1'b0);
    for (int i = 0; i < 128; i++) begin
      push_leaf(8'($urandom));
      put_bit(1'b0);
    end
    push_leaf(8'($urandom));
    flush_bits();
  endtask

  task automatic test_stack_empty();
    // a complete tree of two leaves while three are configured
    write_cfg(htsd_pkg::CfgSymbolCount, 3);
    write_cfg(htsd_pkg::CfgCharCount, 2);
    stream_bits.delete();
    put_bit(1'b0);
    push_leaf(8'h11);
    push_leaf(8'h22);
    flush_bits();
  endtask

  task automatic test_count_extremes();
    run_stream(4, 32'hffff_ffff, 20, 0, 0);
    run_stream(12, 3, 3, 1, 0);
    run_stream(2, 1, 1, 2, 0);
  endtask

  task automatic test_random_streams();
    int n, c, base;
    base = items_sent;
    while (items_sent - base < 55) begin
      tx_busy_mode = ($urandom_range(0, 5) != 0);
      rx_busy_mode = ($urandom_range(0, 5) != 0);
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 32) : $urandom_range(2, 16);
      c = $urandom_range(0, 30);
      if ($urandom_range(0, 7) == 0) begin
        // noise only
        write_cfg(htsd_pkg::CfgSymbolCount, $urandom_range(0, 511));
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end else begin
        run_stream(n, ($urandom_range(0, 3) == 0) ? c + $urandom_range(1, 3) : c, c,
                   $urandom_range(0, 3), $urandom_range(0, 9) == 0);
      end
    end
    tx_busy_mode = 1'b1;
    rx_busy_mode = 1'b1;
  endtask

  task automatic test_backpressure();
    // receiver holds off while the sender keeps offering a long stream
    write_cfg(htsd_pkg::CfgSymbolCount, 8);
    write_cfg(htsd_pkg::CfgCharCount, 60);
    tx_busy_mode = 1'b0;
    rx_long_hold = 400;
    stream_bits.delete();
    leaf_cnt = 0;
    build_tree(8, '0, 0);
    for (int c = 0; c < 60; c++) begin
      int p;
      p = $urandom_range(0, leaf_cnt - 1);
      for (int i = 0; i < code_n[p]; i++) put_bit(code_v[p][i]);
    end
    flush_bits();
    tx_busy_mode = 1'b1;
    wait_drained();
  endtask

  initial begin
    sym_count_reg = htsd_pkg::SymbolCountRst;
    char_count_reg = htsd_pkg::CharCountRst;
    model_restart();
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_reset_defaults();
    test_empty_tree();
    test_single_symbol();
    test_missing_child();
    test_stack_full();
    test_node_table_full();
    test_stack_empty();
    test_count_extremes();
    test_backpressure();
    test_random_streams();
    wait_drained();
    $display("covered %0d input bytes and %0d results (%0d error results)",
             items_sent, results_seen, error_results);
    $display("random trees up to 32 symbols, count limits, stack and node table overflow,");
    $display("corrupted streams and long output stalls");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // run time limit
  initial begin
    #40ms;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
